FILE: rtl/core/rvde_pkg.sv
// ----------------------------------------------------------------------------
// rvde_pkg: shared types and codes for the RV32I decode/execute block
// Opcode, funct3 and class/access codes plus the channel payload structs.
// ----------------------------------------------------------------------------
package rvde_pkg;

  // Default width of the wrapped pc for branches and JAL
  localparam int unsigned PcWrapBitsDefault = 13;

  // Shift amount field width
  localparam int unsigned ShamtBits = 5;

  // Major opcodes
  typedef enum logic [6:0] {
    OPC_LOAD   = 7'b0000011,
    OPC_OPIMM  = 7'b0010011,
    OPC_AUIPC  = 7'b0010111,
    OPC_STORE  = 7'b0100011,
    OPC_OP     = 7'b0110011,
    OPC_LUI    = 7'b0110111,
    OPC_BRANCH = 7'b1100011,
    OPC_JALR   = 7'b1100111,
    OPC_JAL    = 7'b1101111
  } opcode_e;

  // ALU funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Load and store funct3 codes
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SH  = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;

  // Branch funct3 codes
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Instruction format class
  typedef enum logic [2:0] {
    CLS_NONE = 3'd0,
    CLS_R    = 3'd1,
    CLS_I    = 3'd2,
    CLS_S    = 3'd3,
    CLS_B    = 3'd4,
    CLS_U    = 3'd5,
    CLS_J    = 3'd6
  } op_class_e;

  // Memory access code
  typedef enum logic [3:0] {
    MEM_NONE = 4'd0,
    MEM_LB   = 4'd1,
    MEM_LH   = 4'd2,
    MEM_LW   = 4'd3,
    MEM_LBU  = 4'd4,
    MEM_LHU  = 4'd5,
    MEM_SB   = 4'd6,
    MEM_SH   = 4'd7,
    MEM_SW   = 4'd8
  } mem_access_e;

  // Input transaction payload
  typedef struct packed {
    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] src_one;
    logic [31:0] src_two;
    logic [31:0] immediate;
    logic [31:0] current_pc;
  } rvde_in_t;

  // Result transaction payload
  typedef struct packed {
    op_class_e   op_class;
    logic [31:0] result_value;
    logic        result_written;
    logic [31:0] next_pc;
    mem_access_e mem_access;
    logic        illegal;
  } rvde_out_t;

endpackage

FILE: rtl/core/rvde_stream_if.sv
// ----------------------------------------------------------------------------
// rvde_stream_if: valid/ready channel
// Carries one payload of the given type per transaction.
// ----------------------------------------------------------------------------
interface rvde_stream_if
  import rvde_pkg::*;
#(
  parameter type payload_t = rvde_in_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/rv32i_decode_execute_top.sv
// ----------------------------------------------------------------------------
// rv32i_decode_execute_top: RV32I integer decode, ALU and branch unit
// Pipeline: an input register, then decode/ALU logic into the result register.
// Throughput: one instruction per cycle while out_o.ready is held high; no state is kept between items.
// Reset: rst_ni clears both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rv32i_decode_execute_top
  import rvde_pkg::*;
#(
  parameter int unsigned PC_WRAP_BITS = PcWrapBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rvde_stream_if.sink   in_i,
  rvde_stream_if.source out_o
);

  localparam logic [31:0] WrapMask = 32'((64'(1) << PC_WRAP_BITS) - 64'(1));

  // Pipeline registers
  logic      in_vld_q;
  rvde_in_t  in_q;
  logic      out_vld_q;
  rvde_out_t out_q;
  rvde_out_t out_d;

  logic adv_out;
  logic adv_in;

  // Datapath signals
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] imm;
  logic [31:0] pc;
  logic [31:0] alu_b;
  logic [31:0] alu_res;
  logic [31:0] pc_imm;
  logic [31:0] addr;
  logic [ShamtBits-1:0] shamt;
  logic alt;
  logic taken;
  logic bad;
  logic lt_s;
  logic lt_u;

  // Handshake: the result stage frees when empty or taken downstream
  assign adv_out     = !out_vld_q || out_o.ready;
  assign adv_in      = !in_vld_q || adv_out;
  assign in_i.ready  = adv_in;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= in_i.valid;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (adv_in && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (adv_out && in_vld_q) begin
      out_q <= out_d;
    end
  end

  // Shared operands
  assign a      = in_q.src_one;
  assign b      = in_q.src_two;
  assign imm    = in_q.immediate;
  assign pc     = in_q.current_pc;
  assign pc_imm = (pc + imm) & WrapMask;
  assign addr   = a + imm;
  assign lt_s   = $signed(a) < $signed(b);
  assign lt_u   = a < b;

  // Select ALU second operand and alternate op
  always_comb begin
    if (in_q.opcode == OPC_OP) begin
      alu_b = b;
      alt   = (in_q.funct7 != 7'd0);
    end else begin
      alu_b = imm;
      alt   = (in_q.funct3 == F3_SR) && (in_q.funct7 != 7'd0);
    end
  end

  assign shamt = alu_b[ShamtBits-1:0];

  // ALU
  always_comb begin
    case (in_q.funct3)
      F3_ADD: begin
        if ((in_q.opcode == OPC_OP) && alt) begin
          alu_res = a - alu_b;
        end else begin
          alu_res = a + alu_b;
        end
      end
      F3_SLL:  alu_res = a << shamt;
      F3_SLT:  alu_res = {31'd0, ($signed(a) < $signed(alu_b))};
      F3_SLTU: alu_res = {31'd0, (a < alu_b)};
      F3_XOR:  alu_res = a ^ alu_b;
      F3_SR: begin
        if (alt) begin
          alu_res = 32'($signed(a) >>> shamt);
        end else begin
          alu_res = a >> shamt;
        end
      end
      F3_OR:   alu_res = a | alu_b;
      default: alu_res = a & alu_b;
    endcase
  end

  // Decode and build the result
  always_comb begin
    out_d                = '0;
    out_d.op_class       = CLS_NONE;
    out_d.mem_access     = MEM_NONE;
    out_d.next_pc        = pc;
    bad                  = 1'b0;
    taken                = 1'b0;
    case (in_q.opcode)
      OPC_OP: begin
        out_d.op_class       = CLS_R;
        out_d.result_value   = alu_res;
        out_d.result_written = 1'b1;
      end
      OPC_OPIMM: begin
        out_d.op_class       = CLS_I;
        out_d.result_value   = alu_res;
        out_d.result_written = 1'b1;
      end
      OPC_LOAD: begin
        out_d.op_class       = CLS_I;
        out_d.result_value   = addr;
        out_d.result_written = 1'b1;
        case (in_q.funct3)
          F3_LB:   out_d.mem_access = MEM_LB;
          F3_LH:   out_d.mem_access = MEM_LH;
          F3_LW:   out_d.mem_access = MEM_LW;
          F3_LBU:  out_d.mem_access = MEM_LBU;
          F3_LHU:  out_d.mem_access = MEM_LHU;
          default: bad = 1'b1;
        endcase
      end
      OPC_STORE: begin
        out_d.op_class       = CLS_S;
        out_d.result_value   = addr;
        out_d.result_written = 1'b1;
        case (in_q.funct3)
          F3_SB:   out_d.mem_access = MEM_SB;
          F3_SH:   out_d.mem_access = MEM_SH;
          F3_SW:   out_d.mem_access = MEM_SW;
          default: bad = 1'b1;
        endcase
      end
      OPC_BRANCH: begin
        out_d.op_class = CLS_B;
        case (in_q.funct3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = lt_s;
          F3_BGE:  taken = !lt_s;
          F3_BLTU: taken = lt_u;
          F3_BGEU: taken = !lt_u;
          default: bad = 1'b1;
        endcase
        if (taken) begin
          out_d.next_pc = pc_imm;
        end
      end
      OPC_JALR: begin
        out_d.op_class       = CLS_I;
        out_d.result_value   = pc + 32'd4;
        out_d.result_written = 1'b1;
        out_d.next_pc        = {addr[31:1], 1'b0};
      end
      OPC_JAL: begin
        out_d.op_class       = CLS_J;
        out_d.result_value   = pc + 32'd4;
        out_d.result_written = 1'b1;
        out_d.next_pc        = pc_imm;
      end
      OPC_AUIPC: begin
        out_d.op_class       = CLS_U;
        out_d.result_value   = pc + imm;
        out_d.result_written = 1'b1;
      end
      OPC_LUI: begin
        out_d.op_class       = CLS_U;
        out_d.result_value   = imm;
        out_d.result_written = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    // Drop all effects of an unrecognized encoding, keep the class
    if (bad) begin
      out_d.result_value   = '0;
      out_d.result_written = 1'b0;
      out_d.next_pc        = pc;
      out_d.mem_access     = MEM_NONE;
    end
    out_d.illegal = bad;
  end

  // Assertions
  a_in_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> in_vld_q)
    else $error("accepted transaction not captured in input stage");

  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && adv_out) |=> out_o.valid)
    else $error("input stage did not advance into result stage");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while result side is ready");

  a_illegal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.illegal) |->
      (!out_o.data.result_written && (out_o.data.mem_access == MEM_NONE)))
    else $error("illegal instruction produced an effect");

endmodule
